// ----- sv/vfph_pkg.sv -----
`timescale 1ns / 1ps

package vfph_pkg;

  localparam int SIZE_W      = 24;
  localparam int PAYLOAD_W   = 11;
  localparam int SEQ_W       = 16;
  localparam int LIMIT_W     = 18;  // payload size times segment count
  localparam int PCLAMP_W    = 17;  // wide enough for the largest payload bound

  localparam int SEGMENT_PAYLOAD_MAX_DEF = 1400;
  localparam int MAX_SEGMENTS_DEF        = 64;

  localparam logic [PAYLOAD_W-1:0] CFG_RESET = 11'd1400;

  localparam logic [15:0] HEADER_EXTRA_LEN = 16'h0024;
  localparam logic [7:0]  PT_MJPG          = 8'h64;
  localparam logic [7:0]  PT_H264          = 8'h65;
  localparam logic [3:0]  FTYPE_MJPG       = 4'h5;
  localparam logic [3:0]  PART_START       = 4'h1;
  localparam logic [3:0]  PART_MIDDLE      = 4'h2;
  localparam logic [3:0]  PART_END         = 4'h4;
  localparam logic [SEQ_W-1:0] SEQ_LAST    = 16'hFFFF;

  typedef struct packed {
    logic [23:0] frame_size;
    logic        codec;
    logic [7:0]  nal_header_byte;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [31:0] pts_high_word;
    logic [31:0] pts_low_word;
    logic [7:0]  frames_per_second;
  } in_item_t;

  typedef struct packed {
    logic [15:0] seq_num;
    logic [15:0] length_field;
    logic [7:0]  payload_type_byte;
    logic [7:0]  frame_type_byte;
    logic [23:0] segment_offset;
    logic [10:0] segment_length;
    logic        last_segment;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic [63:0] timestamp;
    logic [7:0]  out_fps;
    logic        too_large;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT,
    ST_BIG
  } state_t;

  typedef struct packed {
    logic capture;
    logic track_cfg;
    logic emit_seg;
    logic emit_big;
  } cmd_t;

  typedef struct packed {
    logic in_empty;
    logic too_big;
    logic last_seg;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/vfph_ctrl.sv -----
`timescale 1ns / 1ps

module vfph_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  vfph_pkg::sts_t  sts,
  output vfph_pkg::cmd_t  cmd
);

  vfph_pkg::state_t state;
  vfph_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vfph_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      vfph_pkg::ST_IDLE: begin
        // an empty frame is taken and dropped without leaving idle
        if (in_valid && !sts.in_empty) begin
          state_next = vfph_pkg::ST_CHECK;
        end
      end
      vfph_pkg::ST_CHECK: begin
        state_next = sts.too_big ? vfph_pkg::ST_BIG : vfph_pkg::ST_EMIT;
      end
      vfph_pkg::ST_EMIT: begin
        if (sts.out_free && sts.last_seg) begin
          state_next = vfph_pkg::ST_IDLE;
        end
      end
      vfph_pkg::ST_BIG: begin
        if (sts.out_free) begin
          state_next = vfph_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = vfph_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = (state == vfph_pkg::ST_IDLE);
    cmd.capture   = in_valid && (state == vfph_pkg::ST_IDLE);
    cmd.track_cfg = (state == vfph_pkg::ST_IDLE) || (state == vfph_pkg::ST_CHECK);
    cmd.emit_seg  = (state == vfph_pkg::ST_EMIT) && sts.out_free;
    cmd.emit_big  = (state == vfph_pkg::ST_BIG) && sts.out_free;
  end

endmodule

// ----- sv/vfph_dp.sv -----
`timescale 1ns / 1ps

module vfph_dp #(
  parameter int SEGMENT_PAYLOAD_MAX = vfph_pkg::SEGMENT_PAYLOAD_MAX_DEF,
  parameter int MAX_SEGMENTS        = vfph_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  vfph_pkg::in_item_t                 in_data,
  input  logic                               cfg_wr,
  input  logic [vfph_pkg::PAYLOAD_W-1:0]     cfg_data,
  input  vfph_pkg::cmd_t                     cmd,
  output vfph_pkg::sts_t                     sts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output vfph_pkg::out_item_t                out_data
);

  localparam logic [vfph_pkg::PCLAMP_W-1:0] PMAX = vfph_pkg::PCLAMP_W'(SEGMENT_PAYLOAD_MAX);
  localparam logic [vfph_pkg::LIMIT_W-1:0]  SEGS = vfph_pkg::LIMIT_W'(MAX_SEGMENTS);

  logic [vfph_pkg::PAYLOAD_W-1:0] payload_cfg;
  logic [vfph_pkg::PAYLOAD_W-1:0] p_eff;
  logic [vfph_pkg::PAYLOAD_W-1:0] p_seg;
  logic [vfph_pkg::LIMIT_W-1:0]   limit;

  logic [vfph_pkg::SIZE_W-1:0]    remaining;
  logic [vfph_pkg::SIZE_W-1:0]    offset;
  logic                           first;
  vfph_pkg::in_item_t             frame;
  logic [vfph_pkg::SEQ_W-1:0]     seq;
  logic [vfph_pkg::SEQ_W-1:0]     seq_report;

  logic [vfph_pkg::PAYLOAD_W-1:0] seg_len;
  logic [3:0]                     part;
  logic [3:0]                     ftype;
  vfph_pkg::out_item_t            rec_seg;
  vfph_pkg::out_item_t            rec_big;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_cfg <= vfph_pkg::CFG_RESET;
    end else if (cfg_wr) begin
      payload_cfg <= cfg_data;
    end
  end

  // zero acts as one byte; clamp to the build-time maximum
  always_comb begin
    p_eff = payload_cfg;
    if (payload_cfg == '0) begin
      p_eff = vfph_pkg::PAYLOAD_W'(1);
    end else if (vfph_pkg::PCLAMP_W'(payload_cfg) > PMAX) begin
      p_eff = PMAX[vfph_pkg::PAYLOAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.track_cfg) begin
      p_seg <= p_eff;
      limit <= vfph_pkg::LIMIT_W'(p_eff) * SEGS;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      frame     <= in_data;
      remaining <= in_data.frame_size;
      offset    <= '0;
      first     <= 1'b1;
    end else if (cmd.emit_seg) begin
      remaining <= remaining - vfph_pkg::SIZE_W'(p_seg);
      offset    <= offset + vfph_pkg::SIZE_W'(p_seg);
      first     <= 1'b0;
    end
  end

  assign seq_report = seq + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= '0;
    end else if (cmd.emit_seg) begin
      seq <= (seq_report == vfph_pkg::SEQ_LAST) ? '0 : seq_report;
    end
  end

  always_comb begin
    sts.in_empty = (in_data.frame_size == '0);
    sts.too_big  = (remaining > vfph_pkg::SIZE_W'(limit));
    sts.last_seg = (remaining <= vfph_pkg::SIZE_W'(p_seg));
    sts.out_free = !out_valid || out_ready;
  end

  always_comb begin
    seg_len = sts.last_seg ? remaining[vfph_pkg::PAYLOAD_W-1:0] : p_seg;
    if (sts.last_seg) begin
      part = vfph_pkg::PART_END;
    end else if (first) begin
      part = vfph_pkg::PART_START;
    end else begin
      part = vfph_pkg::PART_MIDDLE;
    end
    ftype = frame.codec ? frame.nal_header_byte[3:0] : vfph_pkg::FTYPE_MJPG;

    rec_seg.seq_num           = seq_report;
    rec_seg.length_field      = vfph_pkg::HEADER_EXTRA_LEN + 16'(seg_len);
    rec_seg.payload_type_byte = frame.codec ? vfph_pkg::PT_H264 : vfph_pkg::PT_MJPG;
    rec_seg.frame_type_byte   = {ftype, part};
    rec_seg.segment_offset    = offset;
    rec_seg.segment_length    = seg_len;
    rec_seg.last_segment      = sts.last_seg;
    rec_seg.out_width         = frame.frame_width;
    rec_seg.out_height        = frame.frame_height;
    rec_seg.timestamp         = {frame.pts_high_word, frame.pts_low_word};
    rec_seg.out_fps           = frame.frames_per_second;
    rec_seg.too_large         = 1'b0;

    rec_big              = '0;
    rec_big.last_segment = 1'b1;
    rec_big.too_large    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_seg || cmd.emit_big) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_seg) begin
      out_data <= rec_seg;
    end else if (cmd.emit_big) begin
      out_data <= rec_big;
    end
  end

endmodule

// ----- sv/video_frame_packet_header_generator.sv -----
`timescale 1ns / 1ps
// ST_IDLE captures a frame and ST_CHECK tests its size; ST_EMIT registers the records.
// A frame of N segments (N <= MAX_SEGMENTS) holds the input until its last record;
//   the segment sequencer builds one record per cycle while out_ready is high.
// An empty frame is dropped in idle; an oversized frame yields one record from ST_BIG.
// Reset (rst, synchronous): payload size 1400, sequence counter 0, output empty.
module video_frame_packet_header_generator #(
  parameter int SEGMENT_PAYLOAD_MAX = vfph_pkg::SEGMENT_PAYLOAD_MAX_DEF,
  parameter int MAX_SEGMENTS        = vfph_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  vfph_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output vfph_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vfph_pkg::PAYLOAD_W-1:0] cfg_data
);

  vfph_pkg::cmd_t cmd;
  vfph_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  vfph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vfph_dp #(
    .SEGMENT_PAYLOAD_MAX (SEGMENT_PAYLOAD_MAX),
    .MAX_SEGMENTS        (MAX_SEGMENTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- sv/vfph_checker.sv -----
`timescale 1ns / 1ps

module vfph_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input vfph_pkg::out_item_t out_data
);

  // hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_big_record: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.too_large |->
      out_data.last_segment && (out_data.seq_num == 16'd0) &&
      (out_data.length_field == 16'd0))
    else $error("oversize record malformed");

  a_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.too_large |->
      out_data.length_field == vfph_pkg::HEADER_EXTRA_LEN + 16'(out_data.segment_length))
    else $error("length field mismatch");

  a_seq_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.too_large |-> out_data.seq_num != 16'd0)
    else $error("zero sequence number on segment record");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind video_frame_packet_header_generator vfph_checker u_vfph_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CFG_SETTLE = 8;
  localparam int unsigned MAX_PRINTED = 40;

  localparam logic CODEC_MJPG = 1'b0;
  localparam logic CODEC_H264 = 1'b1;

  localparam int FILL_ZERO = 0;
  localparam int FILL_ONES = 1;
  localparam int FILL_RAND = 2;

  class header_predictor;
    vfph_pkg::out_item_t expected_headers[$];
    logic [vfph_pkg::PAYLOAD_W-1:0] seg_bytes_cfg;
    logic [vfph_pkg::SEQ_W-1:0] seq_count;
    int errors;

    function new();
      seg_bytes_cfg = vfph_pkg::CFG_RESET;
      seq_count = '0;
      errors = 0;
    endfunction

    function int unsigned eff_payload();
      int unsigned p;
      p = seg_bytes_cfg;
      if (p == 0) p = 1;
      if (p > vfph_pkg::SEGMENT_PAYLOAD_MAX_DEF) p = vfph_pkg::SEGMENT_PAYLOAD_MAX_DEF;
      return p;
    endfunction

    function int pending();
      return expected_headers.size();
    endfunction

    // Work out every header record one accepted frame causes.
    function void note_frame(vfph_pkg::in_item_t f);
      int unsigned p, n, off, len, size;
      vfph_pkg::out_item_t r;
      logic [3:0] ftype;
      logic [3:0] part;
      size = f.frame_size;
      if (size == 0) return;
      p = eff_payload();
      n = (size + p - 1) / p;
      if (n > vfph_pkg::MAX_SEGMENTS_DEF) begin
        r = '0;
        r.last_segment = 1'b1;
        r.too_large = 1'b1;
        expected_headers.push_back(r);
        return;
      end
      ftype = (f.codec == CODEC_H264) ? f.nal_header_byte[3:0] : vfph_pkg::FTYPE_MJPG;
      for (int unsigned i = 0; i < n; i++) begin
        off = i * p;
        len = (i == n - 1) ? size - off : p;
        seq_count = seq_count + 1'b1;
        r.seq_num = seq_count;
        // hold at 65535 for one report, then restart so the next one is 1
        if (seq_count == vfph_pkg::SEQ_LAST) begin
          seq_count = '0;
        end
        if (i == n - 1) part = vfph_pkg::PART_END;
        else if (i == 0) part = vfph_pkg::PART_START;
        else part = vfph_pkg::PART_MIDDLE;
        r.length_field = vfph_pkg::HEADER_EXTRA_LEN + 16'(len);
        r.payload_type_byte = (f.codec == CODEC_H264) ? vfph_pkg::PT_H264 : vfph_pkg::PT_MJPG;
        r.frame_type_byte = {ftype, part};
        r.segment_offset = 24'(off);
        r.segment_length = 11'(len);
        r.last_segment = (i == n - 1);
        r.out_width = f.frame_width;
        r.out_height = f.frame_height;
        r.timestamp = {f.pts_high_word, f.pts_low_word};
        r.out_fps = f.frames_per_second;
        r.too_large = 1'b0;
        expected_headers.push_back(r);
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTED) $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task cmp(string name, logic [63:0] got, logic [63:0] want, int seq);
      if (got !== want)
        report_mismatch($sformatf("record %0d %s got %0h want %0h", seq, name, got, want));
    endtask

    task check_header(vfph_pkg::out_item_t got);
      vfph_pkg::out_item_t want;
      int seq;
      if (expected_headers.size() == 0) begin
        report_mismatch($sformatf("unexpected record seq %0d", got.seq_num));
        return;
      end
      want = expected_headers.pop_front();
      seq = want.seq_num;
      cmp("seq_num", got.seq_num, want.seq_num, seq);
      cmp("length_field", got.length_field, want.length_field, seq);
      cmp("payload_type_byte", got.payload_type_byte, want.payload_type_byte, seq);
      cmp("frame_type_byte", got.frame_type_byte, want.frame_type_byte, seq);
      cmp("segment_offset", got.segment_offset, want.segment_offset, seq);
      cmp("segment_length", got.segment_length, want.segment_length, seq);
      cmp("last_segment", got.last_segment, want.last_segment, seq);
      cmp("out_width", got.out_width, want.out_width, seq);
      cmp("out_height", got.out_height, want.out_height, seq);
      cmp("timestamp", got.timestamp, want.timestamp, seq);
      cmp("out_fps", got.out_fps, want.out_fps, seq);
      cmp("too_large", got.too_large, want.too_large, seq);
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  vfph_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  vfph_pkg::out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [vfph_pkg::PAYLOAD_W-1:0] cfg_data;

  header_predictor sb;
  bit idle_on;
  int unsigned cycle_count;
  int stall_left;

  video_frame_packet_header_generator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_header(out_data);
  end

  // Receiver: drop ready for random stretches while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_ready <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(1, 9);
    end
  end

  function automatic vfph_pkg::in_item_t frame_of(int unsigned size, logic codec,
                                                  logic [7:0] nal, int fill);
    vfph_pkg::in_item_t f;
    f.frame_size = size[23:0];
    f.codec = codec;
    f.nal_header_byte = nal;
    case (fill)
      FILL_ZERO: begin
        f.frame_width = '0;
        f.frame_height = '0;
        f.pts_high_word = '0;
        f.pts_low_word = '0;
        f.frames_per_second = '0;
      end
      FILL_ONES: begin
        f.frame_width = '1;
        f.frame_height = '1;
        f.pts_high_word = '1;
        f.pts_low_word = '1;
        f.frames_per_second = '1;
      end
      default: begin
        f.frame_width = 16'($urandom);
        f.frame_height = 16'($urandom);
        f.pts_high_word = $urandom;
        f.pts_low_word = $urandom;
        f.frames_per_second = 8'($urandom);
      end
    endcase
    return f;
  endfunction

  // Mostly frames that fit in 1 to 64 segments; some empty, oversized or wild.
  function automatic vfph_pkg::in_item_t random_frame(int unsigned p);
    int unsigned pick, n, size;
    pick = $urandom_range(0, 19);
    if (pick == 0) size = 0;
    else if (pick <= 2) size = $urandom & 32'hFF_FFFF;
    else if (pick <= 4) size = vfph_pkg::MAX_SEGMENTS_DEF * p + $urandom_range(1, 3 * p);
    else begin
      n = (pick <= 10) ? $urandom_range(1, 4) : $urandom_range(1, vfph_pkg::MAX_SEGMENTS_DEF);
      size = (n - 1) * p + $urandom_range(1, p);
    end
    return frame_of(size, 1'($urandom_range(0, 1)), 8'($urandom), FILL_RAND);
  endfunction

  task automatic send_frame(vfph_pkg::in_item_t f);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= f;
    do @(posedge clk); while (!in_ready);
    sb.note_frame(f);
  endtask

  task automatic write_payload(logic [vfph_pkg::PAYLOAD_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    // an empty frame may still be in flight with nothing expected
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.seg_bytes_cfg = value;
  endtask

  task automatic random_phase(logic [vfph_pkg::PAYLOAD_W-1:0] value, int count);
    write_payload(value);
    repeat (count) send_frame(random_frame(sb.eff_payload()));
  endtask

  initial begin
    int unsigned p;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    idle_on = 1'b1;
    stall_left = 0;
    cycle_count = 0;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset payload size
    send_frame(frame_of(0, CODEC_MJPG, 8'h00, FILL_ZERO));
    send_frame(frame_of(1, CODEC_MJPG, 8'h00, FILL_ZERO));
    send_frame(frame_of(1, CODEC_H264, 8'hFF, FILL_ONES));
    send_frame(frame_of(1400, CODEC_MJPG, 8'h3C, FILL_RAND));
    send_frame(frame_of(1401, CODEC_H264, 8'h10, FILL_RAND));
    send_frame(frame_of(4200, CODEC_H264, 8'h05, FILL_RAND));
    send_frame(frame_of(89600, CODEC_MJPG, 8'hA7, FILL_RAND));
    send_frame(frame_of(89601, CODEC_H264, 8'h01, FILL_RAND));
    send_frame(frame_of(24'hFF_FFFF, CODEC_H264, 8'hFF, FILL_ONES));
    send_frame(frame_of(0, CODEC_H264, 8'hFF, FILL_ONES));
    send_frame(frame_of(2800, CODEC_H264, 8'hEA, FILL_RAND));

    // zero acts as one byte per segment
    write_payload(11'd0);
    send_frame(frame_of(1, CODEC_H264, 8'h0F, FILL_RAND));
    send_frame(frame_of(2, CODEC_MJPG, 8'h00, FILL_RAND));
    send_frame(frame_of(64, CODEC_H264, 8'h1E, FILL_RAND));
    send_frame(frame_of(65, CODEC_MJPG, 8'h00, FILL_RAND));

    // values above the bound clamp to it
    write_payload(11'h7FF);
    send_frame(frame_of(89600, CODEC_H264, 8'h67, FILL_RAND));
    send_frame(frame_of(89601, CODEC_MJPG, 8'h00, FILL_RAND));
    send_frame(frame_of(1, CODEC_MJPG, 8'h00, FILL_ONES));

    random_phase(11'd1, 28);
    random_phase(11'h7FF, 28);
    random_phase(11'd1400, 28);
    random_phase(11'd0, 28);
    random_phase(11'($urandom_range(2, 40)), 28);
    random_phase(11'($urandom_range(1, 2047)), 28);
    random_phase(11'($urandom_range(41, 1399)), 28);

    // Full 64-segment frames back to back, no idling.
    write_payload(11'($urandom_range(1, 2047)));
    idle_on = 1'b0;
    p = sb.eff_payload();
    repeat (8)
      send_frame(frame_of(63 * p + $urandom_range(1, p), 1'($urandom_range(0, 1)),
                          8'($urandom), FILL_RAND));
    repeat (8) send_frame(random_frame(p));

    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
